/* hw/rtl/sem_pkg.sv */
// Shared types, constants and square-root step functions for the Sobel magnitude block.
`timescale 1ns / 1ps

package sem_pkg;

   localparam int SEM_MAX_WIDTH = 2048;

   localparam int PIX_W        = 8;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int ROW_W        = 12;
   localparam int OUT_COL_W    = 11;
   localparam int MAX_HEIGHT   = 4096;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RESET  = CFG_WIDTH_W'(640);
   localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RESET = CFG_HEIGHT_W'(480);

   // register index, taken from paddr[2]
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [PIX_W-1:0] MAG_CLAMP = 8'hFF;

   // square root of a 16-bit radicand, two result bits per stage
   localparam int RAD_W       = 16;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int SQRT_STAGES = 4;
   localparam int SQRT_STEPS  = ROOT_W / SQRT_STAGES;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]     magnitude;
      logic [ROW_W-1:0]     out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } meta_type;

   typedef struct packed {
      logic [ROOT_W:0]   rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sqrt_type;

   function automatic sqrt_type sqrt_step(input sqrt_type s);
      logic [ROOT_W+2:0] acc;
      logic [ROOT_W+2:0] trial;
      sqrt_type          n;
      acc   = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      n.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (acc >= trial) begin
         n.rem  = (ROOT_W+1)'(acc - trial);
         n.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = acc[ROOT_W:0];
         n.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

   function automatic sqrt_type sqrt_stage(input sqrt_type s);
      sqrt_type t;
      t = s;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         t = sqrt_step(t);
      end
      return t;
   endfunction

endpackage

/* hw/rtl/sobel_edge_magnitude.sv */
// Top level: raster position, line stores, 3x3 window, Sobel sums and magnitude pipeline.
//
//  channel | dir | handshake          | beat
//  req     | in  | req_valid/stall    | req_type: pixel, frame_start
//  rsp     | out | rsp_valid/stall    | rsp_type: magnitude, out_row, out_col, last_of_frame
//  csr     | in  | psel/penable/ready | 32-bit registers image_width (0x0), image_height (0x4)
//
// One pixel per cycle while the output is not stalled; a result passes through the line store
// read, sums, squares and four square-root stages.
// Reset is synchronous, clears counters and valid bits and loads the default image size; line stores are not cleared.
// A stalled output freezes the whole pipeline, and req_stall follows it in the same cycle.
`timescale 1ns / 1ps

module sobel_edge_magnitude
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = SEM_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WID_W > CFG_WIDTH_W) ? WID_W : CFG_WIDTH_W;

   // configuration
   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic                    cfg_write;
   logic [CMP_W-1:0]        width_x;
   logic [CMP_W-1:0]        eff_w;
   logic [CFG_HEIGHT_W-1:0] eff_h;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_WIDTH_RESET;
         height_ff <= CFG_HEIGHT_RESET;
      end else if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[CFG_HEIGHT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
      endcase
   end

   always_comb begin
      width_x = CMP_W'(width_ff);
      if (width_x < CMP_W'(3)) begin
         eff_w = CMP_W'(3);
      end else if (width_x > CMP_W'(MAX_WIDTH)) begin
         eff_w = CMP_W'(MAX_WIDTH);
      end else begin
         eff_w = width_x;
      end
      if (height_ff < CFG_HEIGHT_W'(3)) begin
         eff_h = CFG_HEIGHT_W'(3);
      end else if (height_ff > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
         eff_h = CFG_HEIGHT_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   // pipeline enable
   logic pipe_en;
   logic accept;

   assign pipe_en   = !(rsp_valid && rsp_stall);
   assign req_stall = !pipe_en;
   assign accept    = req_valid && pipe_en;

   // raster position
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [COL_W-1:0]        col_in;
   logic [ROW_W-1:0]        row_in;
   logic [COL_W-1:0]        col_cur;
   logic [ROW_W-1:0]        row_cur;
   logic [CMP_W-1:0]        col_x;
   logic [CMP_W-1:0]        col_inc;
   logic [CFG_HEIGHT_W-1:0] row_x;
   logic [CFG_HEIGHT_W-1:0] row_inc;
   logic                    in_range;
   logic                    emit_in;
   logic                    last_in;

   always_comb begin
      col_cur  = req_data.frame_start ? '0 : col_ff;
      row_cur  = req_data.frame_start ? '0 : row_ff;
      col_x    = CMP_W'(col_cur);
      row_x    = CFG_HEIGHT_W'(row_cur);
      col_inc  = col_x + 1'b1;
      row_inc  = row_x + 1'b1;
      in_range = (col_x < eff_w) && (row_x < eff_h);
      emit_in  = in_range && (row_cur >= ROW_W'(2)) && (col_x >= CMP_W'(2));
      last_in  = (row_x == eff_h - 1'b1) && (col_x == eff_w - 1'b1);
      if (col_inc >= eff_w) begin
         col_in = '0;
         row_in = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
      end else if (row_x >= eff_h) begin
         col_in = '0;
         row_in = '0;
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store read data, window
   logic                    s1_valid_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic [PIX_W-1:0]        s1_pixel_ff;
   logic                    s1_in_range_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;
   logic [PIX_W-1:0]        top_rd_ff;
   logic [PIX_W-1:0]        mid_rd_ff;
   logic                    fwd_ff;
   logic                    fwd_in;
   logic [PIX_W-1:0]        fwd_top_ff;
   logic [PIX_W-1:0]        fwd_mid_ff;
   logic [PIX_W-1:0]        top_s1;
   logic [PIX_W-1:0]        mid_s1;
   logic                    wr_en;
   logic [PIX_W-1:0]        upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0]        middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0]        win_ff     [6];

   assign top_s1 = fwd_ff ? fwd_top_ff : top_rd_ff;
   assign mid_s1 = fwd_ff ? fwd_mid_ff : mid_rd_ff;
   assign wr_en  = pipe_en && s1_valid_ff && s1_in_range_ff;
   // write to the address being read this cycle: pass the new data around the store
   assign fwd_in = wr_en && (s1_col_ff == col_cur);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         top_rd_ff <= upper_mem[col_cur];
      end
      if (wr_en) begin
         upper_mem[s1_col_ff] <= mid_s1;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mid_rd_ff <= middle_mem[col_cur];
      end
      if (wr_en) begin
         middle_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= accept;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_col_ff      <= col_cur;
         s1_row_ff      <= row_cur;
         s1_pixel_ff    <= req_data.pixel;
         s1_in_range_ff <= in_range;
         s1_emit_ff     <= emit_in;
         s1_last_ff     <= last_in;
         fwd_top_ff     <= mid_s1;
         fwd_mid_ff     <= s1_pixel_ff;
      end
   end

   // window: [0..2] column c-2 top/mid/bottom, [3..5] column c-1
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_s1;
         win_ff[4] <= mid_s1;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   logic [PIX_W+1:0]        sum_left;
   logic [PIX_W+1:0]        sum_right;
   logic [PIX_W+1:0]        sum_upper;
   logic [PIX_W+1:0]        sum_lower;
   logic signed [PIX_W+2:0] gx_in;
   logic signed [PIX_W+2:0] gy_in;
   meta_type                meta_in;

   always_comb begin
      sum_left  = {2'b00, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b00, win_ff[2]};
      sum_right = {2'b00, top_s1} + {1'b0, mid_s1, 1'b0} + {2'b00, s1_pixel_ff};
      sum_upper = {2'b00, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b00, top_s1};
      sum_lower = {2'b00, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b00, s1_pixel_ff};
      gx_in     = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      gy_in     = $signed({1'b0, sum_lower}) - $signed({1'b0, sum_upper});
      meta_in.row  = s1_row_ff - 1'b1;
      meta_in.col  = OUT_COL_W'(s1_col_ff - 1'b1);
      meta_in.last = s1_last_ff;
   end

   // stage 2: gradients
   logic                    s2_valid_ff;
   logic signed [PIX_W+2:0] s2_gx_ff;
   logic signed [PIX_W+2:0] s2_gy_ff;
   meta_type                s2_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_gx_ff   <= gx_in;
         s2_gy_ff   <= gy_in;
         s2_meta_ff <= meta_in;
      end
   end

   // stage 3: sum of squares
   logic signed [2*PIX_W+5:0] gx_sq;
   logic signed [2*PIX_W+5:0] gy_sq;
   logic        [2*PIX_W+5:0] sq_sum;
   logic                      s3_valid_ff;
   logic                      s3_sat_ff;
   logic [RAD_W-1:0]          s3_rad_ff;
   meta_type                  s3_meta_ff;

   assign gx_sq  = s2_gx_ff * s2_gx_ff;
   assign gy_sq  = s2_gy_ff * s2_gy_ff;
   assign sq_sum = unsigned'(gx_sq) + unsigned'(gy_sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_sat_ff  <= |sq_sum[2*PIX_W+5:RAD_W];
         s3_rad_ff  <= sq_sum[RAD_W-1:0];
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // stages 4..7: square root
   logic             root_valid;
   logic [PIX_W-1:0] root_mag;
   meta_type         root_meta;

   sem_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_rad_ff),
      .in_sat    (s3_sat_ff),
      .in_meta   (s3_meta_ff),
      .out_valid (root_valid),
      .out_mag   (root_mag),
      .out_meta  (root_meta)
   );

   assign rsp_valid = root_valid;

   always_comb begin
      rsp_data.magnitude     = root_mag;
      rsp_data.out_row       = root_meta.row;
      rsp_data.out_col       = root_meta.col;
      rsp_data.last_of_frame = root_meta.last;
   end

endmodule

/* hw/rtl/sem_isqrt.sv */
// Pipelined floor square root with clamp, carrying beat metadata alongside.
`timescale 1ns / 1ps

module sem_isqrt
   import sem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [RAD_W-1:0] in_rad,
   input  logic             in_sat,
   input  meta_type         in_meta,
   output logic             out_valid,
   output logic [PIX_W-1:0] out_mag,
   output meta_type         out_meta
);

   logic     valid_ff [SQRT_STAGES];
   logic     sat_ff   [SQRT_STAGES];
   meta_type meta_ff  [SQRT_STAGES];
   sqrt_type st_ff    [SQRT_STAGES];
   sqrt_type st_in    [SQRT_STAGES];
   sqrt_type st_init;

   always_comb begin
      st_init.rem  = '0;
      st_init.root = '0;
      st_init.rad  = in_rad;
      st_in[0]     = sqrt_stage(st_init);
      for (int i = 1; i < SQRT_STAGES; i++) begin
         st_in[i] = sqrt_stage(st_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0]   <= st_in[0];
         sat_ff[0]  <= in_sat;
         meta_ff[0] <= in_meta;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            st_ff[i]   <= st_in[i];
            sat_ff[i]  <= sat_ff[i-1];
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_mag   = sat_ff[SQRT_STAGES-1] ? MAG_CLAMP : st_ff[SQRT_STAGES-1].root;
   assign out_meta  = meta_ff[SQRT_STAGES-1];

endmodule

/* hw/rtl/sem_checker.sv */
// Port-level checks for the Sobel magnitude block, bound to the top level.
`timescale 1ns / 1ps

module sem_checker
   import sem_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without output back-pressure");

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_row != '0) && (rsp_data.out_col != '0))
      else $error("border pixel emitted");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);
